[rtl/fxa_pkg.sv]
// Shared types and constants for the signed fixed-point ALU pipeline.
// No dependencies; every other rtl file imports this package.
`default_nettype none
package fxa_pkg;

  typedef enum logic [3:0] {
    OP_ADD    = 4'd0,
    OP_SUB    = 4'd1,
    OP_MUL    = 4'd2,
    OP_DIV    = 4'd3,
    OP_MIN    = 4'd4,
    OP_MAX    = 4'd5,
    OP_INC    = 4'd6,
    OP_DEC    = 4'd7,
    OP_TO_FIX = 4'd8,
    OP_TO_INT = 4'd9
  } op_t;

  // numerator field holds |a| << FRAC_BITS for FRAC_BITS up to 16
  localparam int NUM_W      = 48;
  localparam int DIV_BITS   = 4;
  localparam int DIV_STAGES = NUM_W / DIV_BITS;

  typedef struct packed {
    logic [3:0]         op;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
  } req_t;

  typedef struct packed {
    logic signed [31:0] result;
    logic               a_less;
    logic               a_equal;
    logic               a_greater;
    logic               overflow;
    logic               divide_by_zero;
  } rsp_t;

  typedef struct packed {
    op_t                op;
    logic               lt;
    logic               eq;
    logic               gt;
    logic               neg;
    logic               dbz;
    logic signed [63:0] pre;
    logic [31:0]        mag_a;
    logic [31:0]        den;
    logic [NUM_W-1:0]   num;
    logic [32:0]        rem;
    logic [NUM_W-1:0]   quo;
    logic [63:0]        prod;
  } pipe_t;

endpackage
`default_nettype wire

[rtl/fxa_front.sv]
// Input stage: compare flags, operand magnitudes and simple-op results.
// Depends on fxa_pkg.
`default_nettype none
module fxa_front #(
  parameter int FRAC_BITS = 8
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  input  fxa_pkg::req_t       in_word,
  output logic                ready,
  output logic                valid,
  output fxa_pkg::pipe_t      word,
  input  wire                 down_ready
);
  import fxa_pkg::*;

  pipe_t              nxt;
  logic signed [63:0] sa;
  logic signed [63:0] sb;

  assign ready = !valid || down_ready;

  always_comb begin
    sa = {{32{in_word.operand_a[31]}}, in_word.operand_a};
    sb = {{32{in_word.operand_b[31]}}, in_word.operand_b};
    nxt = '0;
    nxt.op = op_t'(in_word.op);
    nxt.lt = in_word.operand_a < in_word.operand_b;
    nxt.eq = in_word.operand_a == in_word.operand_b;
    nxt.gt = in_word.operand_a > in_word.operand_b;
    nxt.neg = in_word.operand_a[31] ^ in_word.operand_b[31];
    nxt.mag_a = in_word.operand_a[31] ? 32'(-in_word.operand_a) : 32'(in_word.operand_a);
    nxt.den = in_word.operand_b[31] ? 32'(-in_word.operand_b) : 32'(in_word.operand_b);
    nxt.num = NUM_W'({16'd0, nxt.mag_a} << FRAC_BITS);
    nxt.dbz = (in_word.op == OP_DIV) && (in_word.operand_b == 32'sd0);
    case (in_word.op)
      OP_ADD:    nxt.pre = sa + sb;
      OP_SUB:    nxt.pre = sa - sb;
      OP_MIN:    nxt.pre = (sa <= sb) ? sa : sb;
      OP_MAX:    nxt.pre = (sa >= sb) ? sa : sb;
      OP_INC:    nxt.pre = sa + 64'sd1;
      OP_DEC:    nxt.pre = sa - 64'sd1;
      OP_TO_FIX: nxt.pre = sa <<< FRAC_BITS;
      OP_TO_INT: nxt.pre = sa >>> FRAC_BITS;
      default:   nxt.pre = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ready) begin
      valid <= in_valid;
    end
    if (ready && in_valid) begin
      word <= nxt;
    end
  end

endmodule
`default_nettype wire

[rtl/fxa_mul.sv]
// Magnitude multiply stage, 32x32 unsigned, registered product.
// Depends on fxa_pkg.
`default_nettype none
module fxa_mul (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  input  fxa_pkg::pipe_t      in_word,
  output logic                ready,
  output logic                valid,
  output fxa_pkg::pipe_t      word,
  input  wire                 down_ready
);
  import fxa_pkg::*;

  pipe_t nxt;

  assign ready = !valid || down_ready;

  always_comb begin
    nxt = in_word;
    nxt.prod = 64'(in_word.mag_a) * 64'(in_word.den);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ready) begin
      valid <= in_valid;
    end
    if (ready && in_valid) begin
      word <= nxt;
    end
  end

endmodule
`default_nettype wire

[rtl/fxa_div_stage.sv]
// One slice of the restoring divider: DIV_BITS quotient bits per stage.
// Depends on fxa_pkg.
`default_nettype none
module fxa_div_stage (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  input  fxa_pkg::pipe_t      in_word,
  output logic                ready,
  output logic                valid,
  output fxa_pkg::pipe_t      word,
  input  wire                 down_ready
);
  import fxa_pkg::*;

  pipe_t       nxt;
  logic [32:0] rsh;

  assign ready = !valid || down_ready;

  always_comb begin
    nxt = in_word;
    rsh = '0;
    for (int i = 0; i < DIV_BITS; i++) begin
      // rem stays below den, so the top bit is always clear here
      rsh = {nxt.rem[31:0], nxt.num[NUM_W-1]};
      nxt.num = {nxt.num[NUM_W-2:0], 1'b0};
      if (rsh >= {1'b0, nxt.den}) begin
        nxt.rem = rsh - {1'b0, nxt.den};
        nxt.quo = {nxt.quo[NUM_W-2:0], 1'b1};
      end else begin
        nxt.rem = rsh;
        nxt.quo = {nxt.quo[NUM_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ready) begin
      valid <= in_valid;
    end
    if (ready && in_valid) begin
      word <= nxt;
    end
  end

endmodule
`default_nettype wire

[rtl/fxa_round.sv]
// Rounding stage: half-away-from-zero for multiply and divide, sign applied.
// Depends on fxa_pkg.
`default_nettype none
module fxa_round #(
  parameter int FRAC_BITS = 8
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  input  fxa_pkg::pipe_t      in_word,
  output logic                ready,
  output logic                valid,
  output fxa_pkg::pipe_t      word,
  input  wire                 down_ready
);
  import fxa_pkg::*;

  localparam logic [63:0] HALF = (64'd1 << FRAC_BITS) >> 1;

  pipe_t       nxt;
  logic [63:0] mmag;
  logic [63:0] dmag;

  assign ready = !valid || down_ready;

  always_comb begin
    nxt = in_word;
    mmag = (in_word.prod + HALF) >> FRAC_BITS;
    dmag = 64'(in_word.quo) + 64'({in_word.rem, 1'b0} >= {2'b00, in_word.den});
    case (in_word.op)
      OP_MUL:  nxt.pre = in_word.neg ? -$signed(mmag) : $signed(mmag);
      OP_DIV: begin
        if (in_word.dbz) begin
          nxt.pre = '0;
        end else begin
          nxt.pre = in_word.neg ? -$signed(dmag) : $signed(dmag);
        end
      end
      default: nxt.pre = in_word.pre;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ready) begin
      valid <= in_valid;
    end
    if (ready && in_valid) begin
      word <= nxt;
    end
  end

endmodule
`default_nettype wire

[rtl/fxa_sat.sv]
// Saturation to WORD_BITS and the output register.
// Depends on fxa_pkg.
`default_nettype none
module fxa_sat #(
  parameter int WORD_BITS = 32
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  input  fxa_pkg::pipe_t      in_word,
  output logic                ready,
  output logic                valid,
  output fxa_pkg::rsp_t       word,
  input  wire                 stall
);
  import fxa_pkg::*;

  localparam logic signed [63:0] HI = (64'sd1 <<< (WORD_BITS - 1)) - 64'sd1;
  localparam logic signed [63:0] LO = -HI - 64'sd1;

  rsp_t nxt;

  assign ready = !valid || !stall;

  always_comb begin
    nxt = '0;
    nxt.a_less = in_word.lt;
    nxt.a_equal = in_word.eq;
    nxt.a_greater = in_word.gt;
    nxt.divide_by_zero = in_word.dbz;
    if (in_word.pre > HI) begin
      nxt.result = HI[31:0];
      nxt.overflow = 1'b1;
    end else if (in_word.pre < LO) begin
      nxt.result = LO[31:0];
      nxt.overflow = 1'b1;
    end else begin
      nxt.result = in_word.pre[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ready) begin
      valid <= in_valid;
    end
    if (ready && in_valid) begin
      word <= nxt;
    end
  end

endmodule
`default_nettype wire

[rtl/signed_fixed_point_alu.sv]
// Top level of the signed fixed-point ALU: front, multiply, divider slices,
// rounding and saturation stages. Depends on fxa_pkg and the fxa_* modules.
//
//   channel  | signals                  | word
//   ---------+--------------------------+---------------------------------
//   request  | req_valid, req_stall     | req: op, operand_a, operand_b
//   response | rsp_valid, rsp_stall     | rsp: result, flags
//
// One word enters per cycle while rsp_stall is low; the divider slices take
// four quotient bits each. Every stage holds its own valid bit and fills
// bubbles while the output is stalled. rst is synchronous and clears only
// the valid bits.
`default_nettype none
module signed_fixed_point_alu #(
  parameter int FRAC_BITS = 8,
  parameter int WORD_BITS = 32
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 req_valid,
  output logic                req_stall,
  input  fxa_pkg::req_t       req,
  output logic                rsp_valid,
  input  wire                 rsp_stall,
  output fxa_pkg::rsp_t       rsp
);
  import fxa_pkg::*;

  logic  front_ready, front_valid;
  pipe_t front_word;
  logic  mul_ready, mul_valid;
  pipe_t mul_word;
  logic  rnd_ready, rnd_valid;
  pipe_t rnd_word;
  logic  sat_ready;

  logic  dv_ready [DIV_STAGES];
  logic  dv_valid [DIV_STAGES];
  pipe_t dv_word  [DIV_STAGES];

  assign req_stall = !front_ready;

  fxa_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk(clk), .rst(rst),
    .in_valid(req_valid), .in_word(req), .ready(front_ready),
    .valid(front_valid), .word(front_word), .down_ready(mul_ready)
  );

  fxa_mul u_mul (
    .clk(clk), .rst(rst),
    .in_valid(front_valid), .in_word(front_word), .ready(mul_ready),
    .valid(mul_valid), .word(mul_word), .down_ready(dv_ready[0])
  );

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    if (g == 0) begin : g_first
      fxa_div_stage u_div (
        .clk(clk), .rst(rst),
        .in_valid(mul_valid), .in_word(mul_word), .ready(dv_ready[g]),
        .valid(dv_valid[g]), .word(dv_word[g]),
        .down_ready((g == DIV_STAGES - 1) ? rnd_ready : dv_ready[(g + 1) % DIV_STAGES])
      );
    end else begin : g_rest
      fxa_div_stage u_div (
        .clk(clk), .rst(rst),
        .in_valid(dv_valid[g - 1]), .in_word(dv_word[g - 1]), .ready(dv_ready[g]),
        .valid(dv_valid[g]), .word(dv_word[g]),
        .down_ready((g == DIV_STAGES - 1) ? rnd_ready : dv_ready[(g + 1) % DIV_STAGES])
      );
    end
  end

  fxa_round #(.FRAC_BITS(FRAC_BITS)) u_round (
    .clk(clk), .rst(rst),
    .in_valid(dv_valid[DIV_STAGES - 1]), .in_word(dv_word[DIV_STAGES - 1]),
    .ready(rnd_ready), .valid(rnd_valid), .word(rnd_word), .down_ready(sat_ready)
  );

  fxa_sat #(.WORD_BITS(WORD_BITS)) u_sat (
    .clk(clk), .rst(rst),
    .in_valid(rnd_valid), .in_word(rnd_word), .ready(sat_ready),
    .valid(rsp_valid), .word(rsp), .stall(rsp_stall)
  );

endmodule
`default_nettype wire
